@@ src/svu_pkg.sv @@
// Package for the signal vector unit: command codes, configuration indices, beat structs and fixed constants.
// No dependencies; the top level and the checker use it.
package svu_pkg;

  typedef enum logic [3:0] {
    CMD_FILL     = 4'd0,
    CMD_DIVIDE   = 4'd1,
    CMD_CORRECT  = 4'd2,
    CMD_REMOVE   = 4'd3,
    CMD_QUERY    = 4'd4,
    CMD_ADD      = 4'd5,
    CMD_MIN      = 4'd6,
    CMD_MAX      = 4'd7,
    CMD_DIST     = 4'd8,
    CMD_DIST_MSK = 4'd9,
    CMD_DISJOINT = 4'd10
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_QUAD = 2'd0,
    CFG_LIN  = 2'd1,
    CFG_OFF  = 2'd2
  } cfg_e;

  localparam int COEF_BITS   = 32;
  localparam int MUL_A_BITS  = 33;
  localparam int OPND_BITS   = 16;
  localparam int DIST_BITS   = 36;
  localparam int CLAMP_HIGH  = 255;
  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};
  localparam logic [COEF_BITS-1:0] LIN_RESET = 32'h0001_0000;

  typedef struct packed {
    logic [3:0]           command;
    logic [3:0]           ap_index;
    logic [OPND_BITS-1:0] operand;
    logic                 last;
  } item_t;

  typedef struct packed {
    logic                 done_res;
    logic [DIST_BITS-1:0] distance;
    logic [4:0]           visible_count;
    logic                 any_visible;
    logic                 disjoint;
    logic                 divide_error;
  } result_t;

endpackage

@@ src/svu_mul.sv @@
// Shared signed multiplier of the signal vector unit, with a registered product.
// Depends on nothing but its parameters.
module svu_mul #(
  parameter int AW = 33,
  parameter int BW = 17
) (
  input  logic                 clk,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

@@ src/svu_div.sv @@
// Restoring divider of the signal vector unit: one quotient bit per cycle.
// Depends on nothing but its parameters.
module svu_div #(
  parameter int DW = 16,
  parameter int VW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [VW:0]   rem;
  logic [VW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [VW:0]   shifted;
  logic          take;

  assign shifted = {rem[VW-1:0], quotient[DW-1]};
  assign take    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= CW'(DW);
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        rem      <= take ? shifted - {1'b0, dvs} : shifted;
        quotient <= {quotient[DW-2:0], take};
        cnt      <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ src/signal_vector_unit.sv @@
// Top level of the signal vector unit: entry vector, sequencer and result register.
// Depends on svu_pkg, svu_mul and svu_div.
//
// Usage. Items arrive on the in channel (in_valid, in_ready, in_item) and each one
// yields exactly one result beat on the out channel (out_valid, out_ready,
// out_result). Correction coefficients are written on the cfg channel, which is
// always ready; write them only while the block is idle.
// The block takes one item at a time and is not ready while the sequencer works
// on it. For fill, divide, correct and remove the sequencer walks the vector
// one entry at a time, correct through the shared multiplier and divide through
// the bit-serial divider.
// The result sits in an output register; the next item is accepted while it
// waits, and a stalled receiver holds the block only at the end of that item.
// Reset clears the vector, the distance accumulator and the result register,
// sets the disjoint flag and loads the coefficient reset values.
module signal_vector_unit #(
  parameter int NUM_ENTRIES = 16,
  parameter int ENTRY_BITS  = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  svu_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output svu_pkg::result_t out_result,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [31:0]    cfg_data
);
  import svu_pkg::*;

  localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int OW = (ENTRY_BITS > OPND_BITS) ? ENTRY_BITS : OPND_BITS;
  localparam int VB = OW + 1;
  localparam int PW = MUL_A_BITS + VB;
  localparam logic [IW-1:0] LAST_PTR = IW'(NUM_ENTRIES - 1);
  localparam logic [OW-1:0] ENTRY_MAX = OW'({ENTRY_BITS{1'b1}});

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_START    = 13'b0000000000010,
    S_FILL     = 13'b0000000000100,
    S_DIV_GO   = 13'b0000000001000,
    S_DIV_WAIT = 13'b0000000010000,
    S_COR_A    = 13'b0000000100000,
    S_COR_B    = 13'b0000001000000,
    S_COR_C    = 13'b0000010000000,
    S_REM_RD   = 13'b0000100000000,
    S_REM_WR   = 13'b0001000000000,
    S_ELEM     = 13'b0010000000000,
    S_DIST     = 13'b0100000000000,
    S_FINISH   = 13'b1000000000000
  } state_t;

  state_t state;

  // Entry vector and its nonzero bits.
  logic [ENTRY_BITS-1:0] ent [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] nz;

  // Latched item.
  logic [3:0]           cmd;
  logic [3:0]           idx;
  logic [OPND_BITS-1:0] opd;
  logic                 lst;
  logic                 idx_ok;

  logic [IW-1:0]         ptr;
  logic [ENTRY_BITS-1:0] hold;
  logic                  cur_nz;
  logic                  div_err;
  logic [DIST_BITS-1:0]  accum;
  logic                  disj_flag;

  logic signed [COEF_BITS-1:0] corr_quad, corr_lin, corr_off;

  // Read port, one address a cycle.
  logic [IW-1:0]         rd_addr;
  logic [ENTRY_BITS-1:0] rd;

  // Write port.
  logic                  we;
  logic [IW-1:0]         waddr;
  logic [ENTRY_BITS-1:0] wdata;

  logic [IW+3:0] idx_ext;
  logic [OW-1:0] opd_w, cur_w, opd_sat, dif;
  logic [OW:0]   add_sum;
  logic [ENTRY_BITS-1:0] cur;

  logic signed [MUL_A_BITS-1:0] mul_a;
  logic signed [VB-1:0]         mul_b;
  logic signed [PW-1:0]         prod;

  logic signed [PW:0] t_val, v_val;
  logic               t_ok;
  logic [PW:0]        dsum;
  logic [6:0]         cnt_all;

  logic                  div_start, div_done;
  logic [ENTRY_BITS-1:0] div_q;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign idx_ext   = {{IW{1'b0}}, idx};
  assign rd        = ent[rd_addr];
  assign cur       = idx_ok ? rd : '0;
  assign opd_w     = OW'(opd);
  assign cur_w     = OW'(cur);
  assign opd_sat   = (opd_w > ENTRY_MAX) ? ENTRY_MAX : opd_w;
  assign add_sum   = {1'b0, cur_w} + {1'b0, opd_w};
  assign dif       = (cur_w > opd_w) ? cur_w - opd_w : opd_w - cur_w;
  assign t_val     = $signed({prod[PW-1], prod}) + (PW+1)'(corr_lin);
  assign v_val     = $signed({prod[PW-1], prod}) + (PW+1)'(corr_off);
  // The linear term lands in range only when it fits 33 signed bits; beyond that
  // the sign alone decides between zero and the clamp value.
  assign t_ok      = (&t_val[PW:32]) | ~(|t_val[PW:32]);
  assign dsum      = (PW+1)'(accum) + {1'b0, prod};
  assign cnt_all   = 7'($countones(nz));

  always_comb begin
    rd_addr = ptr;
    if (state == S_REM_RD) begin
      rd_addr = ptr + 1'b1;
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = $signed(VB'(rd));
    case (state)
      S_COR_A: mul_a = MUL_A_BITS'(corr_quad);
      S_COR_B: mul_a = t_val[MUL_A_BITS-1:0];
      S_ELEM: begin
        mul_a = $signed(MUL_A_BITS'(dif));
        mul_b = $signed(VB'(dif));
      end
      default: mul_a = '0;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = ptr;
    wdata = '0;
    div_start = (state == S_DIV_GO);
    case (state)
      S_FILL: begin
        we    = 1'b1;
        wdata = opd_sat[ENTRY_BITS-1:0];
      end
      S_DIV_WAIT: begin
        we    = div_done;
        wdata = div_q;
      end
      S_COR_B: begin
        we    = !t_ok;
        wdata = t_val[PW] ? '0 : ENTRY_BITS'(CLAMP_HIGH);
      end
      S_COR_C: begin
        we = 1'b1;
        if (v_val[PW]) begin
          wdata = '0;
        end else if (|v_val[PW:24]) begin
          wdata = ENTRY_BITS'(CLAMP_HIGH);
        end else begin
          wdata = ENTRY_BITS'(v_val[23:16]);
        end
      end
      S_REM_RD: begin
        we    = (ptr == LAST_PTR);
        wdata = '0;
      end
      S_REM_WR: begin
        we    = 1'b1;
        wdata = hold;
      end
      S_ELEM: begin
        if (idx_ok) begin
          case (cmd)
            CMD_ADD: begin
              we    = 1'b1;
              wdata = (add_sum > {1'b0, ENTRY_MAX}) ? ENTRY_MAX[ENTRY_BITS-1:0]
                                                     : add_sum[ENTRY_BITS-1:0];
            end
            CMD_MIN: begin
              we    = opd_w < cur_w;
              wdata = opd_w[ENTRY_BITS-1:0];
            end
            CMD_MAX: begin
              we    = opd_sat > cur_w;
              wdata = opd_sat[ENTRY_BITS-1:0];
            end
            default: we = 1'b0;
          endcase
        end
      end
      default: we = 1'b0;
    endcase
  end

  svu_mul #(.AW(MUL_A_BITS), .BW(VB)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  svu_div #(.DW(ENTRY_BITS), .VW(OPND_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rd),
    .divisor  (opd),
    .done     (div_done),
    .quotient (div_q)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      corr_quad <= '0;
      corr_lin  <= LIN_RESET;
      corr_off  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_QUAD: corr_quad <= cfg_data;
        CFG_LIN:  corr_lin  <= cfg_data;
        CFG_OFF:  corr_off  <= cfg_data;
        default:  corr_off  <= corr_off;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        ent[i] <= '0;
      end
      nz <= '0;
    end else if (we) begin
      ent[waddr] <= wdata;
      nz[waddr]  <= |wdata;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      out_result <= '0;
      accum      <= '0;
      disj_flag  <= 1'b1;
      ptr        <= '0;
    end else begin
      // In the finish state a taken beat is replaced by the next one below.
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd     <= in_item.command;
            idx     <= in_item.ap_index;
            opd     <= in_item.operand;
            lst     <= in_item.last;
            idx_ok  <= {28'd0, in_item.ap_index} < 32'(NUM_ENTRIES);
            div_err <= 1'b0;
            state   <= S_START;
          end
        end
        S_START: begin
          ptr   <= '0;
          state <= S_FINISH;
          case (cmd)
            CMD_FILL:    state <= S_FILL;
            CMD_DIVIDE: begin
              if (opd == '0) begin
                div_err <= 1'b1;
              end else begin
                state <= S_DIV_GO;
              end
            end
            CMD_CORRECT: state <= S_COR_A;
            CMD_REMOVE: begin
              if (idx_ok) begin
                ptr   <= idx_ext[IW-1:0];
                state <= S_REM_RD;
              end
            end
            CMD_QUERY:   state <= S_FINISH;
            CMD_ADD, CMD_MIN, CMD_MAX, CMD_DIST, CMD_DIST_MSK, CMD_DISJOINT: begin
              ptr   <= idx_ext[IW-1:0];
              state <= S_ELEM;
            end
            default:     state <= S_FINISH;
          endcase
        end
        S_FILL: begin
          ptr <= ptr + 1'b1;
          if (ptr == LAST_PTR) begin
            state <= S_FINISH;
          end
        end
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) begin
            ptr   <= ptr + 1'b1;
            state <= (ptr == LAST_PTR) ? S_FINISH : S_DIV_GO;
          end
        end
        S_COR_A: begin
          if (rd == '0) begin
            ptr   <= ptr + 1'b1;
            state <= (ptr == LAST_PTR) ? S_FINISH : S_COR_A;
          end else begin
            state <= S_COR_B;
          end
        end
        S_COR_B: begin
          if (t_ok) begin
            state <= S_COR_C;
          end else begin
            ptr   <= ptr + 1'b1;
            state <= (ptr == LAST_PTR) ? S_FINISH : S_COR_A;
          end
        end
        S_COR_C: begin
          ptr   <= ptr + 1'b1;
          state <= (ptr == LAST_PTR) ? S_FINISH : S_COR_A;
        end
        S_REM_RD: begin
          if (ptr == LAST_PTR) begin
            state <= S_FINISH;
          end else begin
            hold  <= rd;
            state <= S_REM_WR;
          end
        end
        S_REM_WR: begin
          ptr   <= ptr + 1'b1;
          state <= S_REM_RD;
        end
        S_ELEM: begin
          cur_nz <= (cur != '0);
          state  <= S_FINISH;
          if (cmd == CMD_DIST || cmd == CMD_DIST_MSK) begin
            state <= S_DIST;
          end
          if (cmd == CMD_DISJOINT && cur != '0 && opd != '0) begin
            disj_flag <= 1'b0;
          end
        end
        S_DIST: begin
          if (cmd == CMD_DIST || cur_nz) begin
            accum <= (dsum > (PW+1)'(DIST_MAX)) ? DIST_MAX : dsum[DIST_BITS-1:0];
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_result.done_res <= (cmd <= CMD_QUERY) ? 1'b1
                                 : (cmd <= CMD_DISJOINT) ? lst : 1'b0;
            out_result.distance <= (cmd == CMD_DIST || cmd == CMD_DIST_MSK) ? accum : '0;
            out_result.visible_count <= (cnt_all > 7'd31) ? 5'd31 : cnt_all[4:0];
            out_result.any_visible   <= |nz;
            out_result.disjoint      <= (cmd == CMD_DISJOINT) ? disj_flag : 1'b0;
            out_result.divide_error  <= div_err;
            // A last element beat closes the run.
            if (cmd >= CMD_ADD && cmd <= CMD_DISJOINT && lst) begin
              accum     <= '0;
              disj_flag <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ src/svu_checker.sv @@
// Port-level checker for the signal vector unit and its bind to the top level.
// Depends on svu_pkg and the top level's port list.
module svu_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input svu_pkg::result_t out_result
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_result))
    else $error("result beat changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a second item back to back");

  a_visible: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_result.any_visible == (out_result.visible_count != 5'd0))
    else $error("visible flag disagrees with count");

  a_div_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_result.divide_error |->
      out_result.done_res && out_result.distance == '0 && !out_result.disjoint)
    else $error("divide error beat carries other results");

endmodule

bind signal_vector_unit svu_checker u_svu_checker (.*);
